FILE: src/complex_arithmetic_unit_core_defines.svh
// ----------------------------------------------------------------------------
// Complex arithmetic unit: assertion macros
// Shared clocked assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Clocked property, masked during reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled result transaction keeps the given signal.
`define CAU_ASSERT_STALL(lbl, sig, msg) \
  `CAU_ASSERT(lbl, (out_valid && !out_ready) |=> $stable(sig), msg)

`endif

FILE: src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int WORD_BITS_DEF   = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OPCODE_W        = 3;
  localparam int STATUS_W        = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_EQ   = 3'd5,
    OP_MAG  = 3'd6,
    OP_NONE = 3'd7
  } opcode_t;

  // Work class decided by the front end
  typedef enum logic [3:0] {
    CL_ADD,
    CL_SUB,
    CL_NEG,
    CL_EQ,
    CL_DIVZ,
    CL_NOP,
    CL_MUL,
    CL_DIV,
    CL_MAG
  } class_t;

  localparam int CLS_W = $bits(class_t);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULT,
    BK_COMB,
    BK_DIV,
    BK_SQRT,
    BK_FIN
  } bk_state_t;

endpackage

`default_nettype wire

FILE: src/cau_if.sv
// ----------------------------------------------------------------------------
// cau_in_if / cau_out_if
// Valid/ready channels of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_in_if #(parameter int W = cau_pkg::WORD_BITS_DEF) ();
  logic                           valid;
  logic                           ready;
  logic [cau_pkg::OPCODE_W-1:0]   opcode;
  logic signed [W-1:0]            a_re;
  logic signed [W-1:0]            a_im;
  logic signed [W-1:0]            b_re;
  logic signed [W-1:0]            b_im;

  modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int W = cau_pkg::WORD_BITS_DEF) ();
  logic                           valid;
  logic                           ready;
  logic signed [W-1:0]            res_re;
  logic signed [W-1:0]            res_im;
  logic                           is_equal;
  logic [cau_pkg::STATUS_W-1:0]   status;

  modport source (output valid, res_re, res_im, is_equal, status, input ready);
  modport sink   (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

`default_nettype wire

FILE: src/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Fixed-point complex ALU: add, sub, mul, div, negate, equal, magnitude.
// ----------------------------------------------------------------------------
// Throughput: add, subtract, negate, equal, divide-by-zero and the unused
// opcode complete one transaction per cycle while the back end is idle and
// the output register is free. Multiply, divide and magnitude run in the
// back end on one shared WORD_BITS x WORD_BITS multiplier, one product per
// cycle: multiply forms 4 products, magnitude 2 products plus one root bit
// per cycle, divide 6 products plus one quotient bit per cycle on both
// parts at once, with Q16.16 as the default format.
// A QUEUE_DEPTH entry queue lets the front keep taking transactions while
// the back end is busy, and the output register lets a new result be
// worked on while the previous one waits for out_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_core #(
  parameter int WORD_BITS   = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS   = cau_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = cau_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cau_in_if.sink     in_ch,
  cau_out_if.source  out_ch
);
  import cau_pkg::*;

  // queue entry: class, equality flag, four operand words
  localparam int QW = CLS_W + 1 + 4 * WORD_BITS;

  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  // front end: decode and cheap tests
  cau_front #(
    .W  (WORD_BITS),
    .QW (QW)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  cau_queue #(
    .DW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back end: execution and result register
  cau_back #(
    .W  (WORD_BITS),
    .F  (FRAC_BITS),
    .QW (QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: src/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Takes input transactions, decodes the opcode into a work class and
// resolves the cheap tests (zero divisor, equality) before queueing.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
  parameter int W  = cau_pkg::WORD_BITS_DEF,
  parameter int QW = cau_pkg::CLS_W + 1 + 4 * cau_pkg::WORD_BITS_DEF
) (
  cau_in_if.sink         in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output logic [QW-1:0]  push_data
);
  import cau_pkg::*;

  class_t cls;
  logic   b_zero;
  logic   eq;

  assign b_zero = (in_ch.b_re == '0) && (in_ch.b_im == '0);

  always_comb begin
    eq  = 1'b0;
    cls = CL_NOP;
    case (opcode_t'(in_ch.opcode))
      OP_ADD:  cls = CL_ADD;
      OP_SUB:  cls = CL_SUB;
      OP_MUL:  cls = CL_MUL;
      OP_DIV:  cls = b_zero ? CL_DIVZ : CL_DIV;
      OP_NEG:  cls = CL_NEG;
      OP_EQ: begin
        cls = CL_EQ;
        eq  = (in_ch.a_re == in_ch.b_re) && (in_ch.a_im == in_ch.b_im);
      end
      OP_MAG:  cls = CL_MAG;
      OP_NONE: cls = CL_NOP;
      default: cls = CL_NOP;
    endcase
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;
  assign push_data   = {cls, eq, in_ch.a_re, in_ch.a_im, in_ch.b_re, in_ch.b_im};

endmodule

`default_nettype wire

FILE: src/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue
// Short register queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = cau_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Execution back end: add/sub/negate/equal from the queue head, a shared
// multiplier stepped over the products, a bit-serial divider pair and a
// digit-serial square root, all feeding one output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back #(
  parameter int W  = cau_pkg::WORD_BITS_DEF,
  parameter int F  = cau_pkg::FRAC_BITS_DEF,
  parameter int QW = cau_pkg::CLS_W + 1 + 4 * cau_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  logic [QW-1:0] pop_data,
  cau_out_if.source     out_ch
);
  import cau_pkg::*;

  localparam int PW    = 2 * W + 1;      // signed sum of two products
  localparam int DW2   = 2 * W;
  localparam int NW    = PW + F;         // dividend / quotient width
  localparam int RW    = W + 4;          // square root remainder
  localparam int CW    = $clog2(NW + 1);
  localparam int NSLOT = 6;
  localparam int KW    = $clog2(NSLOT);
  localparam logic [PW-1:0] HALF = (F > 0) ? (PW'(1) << ((F > 0) ? (F - 1) : 0)) : '0;
  localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};

  // saturate a W+1 bit sum; top bit of the result flags clamping
  function automatic logic [W:0] sat_n1(input logic [W:0] v);
    if (v[W] != v[W-1]) return {1'b1, (v[W] ? MINW : MAXW)};
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] sat_p(input logic [PW-1:0] v);
    if ((&v[PW-1:W-1]) || !(|v[PW-1:W-1])) return {1'b0, v[W-1:0]};
    return {1'b1, (v[PW-1] ? MINW : MAXW)};
  endfunction

  // quotient magnitude and sign to saturated word
  function automatic logic [W:0] div_fin(input logic [NW-1:0] q, input logic neg);
    logic ovf;
    ovf = (|q[NW-1:W]) || (neg ? (q[W-1] && (|q[W-2:0])) : q[W-1]);
    if (ovf) return {1'b1, (neg ? MINW : MAXW)};
    return {1'b0, (neg ? (~q[W-1:0] + 1'b1) : q[W-1:0])};
  endfunction

  function automatic logic [PW-1:0] sx(input logic [DW2-1:0] v);
    return {v[DW2-1], v};
  endfunction

  // queue head
  logic [CLS_W-1:0] q_cls_raw;
  class_t           q_cls;
  logic             q_eq;
  logic [W-1:0]     q_ar, q_ai, q_br, q_bi;
  assign {q_cls_raw, q_eq, q_ar, q_ai, q_br, q_bi} = pop_data;
  assign q_cls = class_t'(q_cls_raw);

  // control
  bk_state_t       state_r, state_nxt;
  class_t          cls_r, cls_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ov_r, ov_nxt;

  // payload
  logic [W-1:0]    ar_r, ai_r, br_r, bi_r, ar_nxt, ai_nxt, br_nxt, bi_nxt;
  logic [DW2-1:0]  slot_r [NSLOT];
  logic [NW-1:0]   dre_r, dim_r, dre_nxt, dim_nxt;
  logic [DW2-1:0]  rre_r, rim_r, rre_nxt, rim_nxt;
  logic [DW2-1:0]  den_r, den_nxt;
  logic            nre_r, nim_r, nre_nxt, nim_nxt;
  logic [DW2-1:0]  rad_r, rad_nxt;
  logic [RW-1:0]   srem_r, srem_nxt;
  logic [W-1:0]    root_r, root_nxt;
  logic [W-1:0]    fre_r, fim_r, fre_nxt, fim_nxt;
  status_t         fst_r, fst_nxt;
  logic [W-1:0]    ore_r, oim_r, ore_nxt, oim_nxt;
  logic            oeq_r, oeq_nxt;
  status_t         ost_r, ost_nxt;

  logic            out_free;
  logic            q_simple;
  logic [KW-1:0]   k_last;

  // shared multiplier
  logic signed [W-1:0]   mx, my;
  logic signed [DW2-1:0] mp;
  logic                  mult_en;

  // combinational datapath pieces
  logic [W:0]      s_re, s_im, t_re, t_im;
  logic [W:0]      s_re_sat, s_im_sat, t_re_sat, t_im_sat;
  logic [PW-1:0]   m_re_sum, m_im_sum, m_re_sh, m_im_sh;
  logic [W:0]      m_re_sat, m_im_sat;
  logic [PW-1:0]   n_re, n_im, n_re_mag, n_im_mag;
  logic [DW2:0]    dsh_re, dsh_im, ddf_re, ddf_im;
  logic            dge_re, dge_im;
  logic [RW-1:0]   ssh, strial, sdf;
  logic            sge;
  logic [W:0]      d_re_fin, d_im_fin;

  assign out_free      = !ov_r || out_ch.ready;
  assign out_ch.valid  = ov_r;
  assign out_ch.res_re = ore_r;
  assign out_ch.res_im = oim_r;
  assign out_ch.is_equal = oeq_r;
  assign out_ch.status = ost_r;

  always_comb begin
    q_simple = 1'b1;
    case (q_cls)
      CL_MUL, CL_DIV, CL_MAG: q_simple = 1'b0;
      default:                q_simple = 1'b1;
    endcase
  end

  always_comb begin
    case (cls_r)
      CL_MUL:  k_last = KW'(3);
      CL_DIV:  k_last = KW'(5);
      default: k_last = KW'(1);
    endcase
  end

  // operand selection per product step
  always_comb begin
    case (k_r)
      KW'(0):  begin mx = ar_r; my = (cls_r == CL_MAG) ? ar_r : br_r; end
      KW'(1):  begin mx = ai_r; my = (cls_r == CL_MAG) ? ai_r : bi_r; end
      KW'(2):  begin mx = ai_r; my = br_r; end
      KW'(3):  begin mx = ar_r; my = bi_r; end
      KW'(4):  begin mx = br_r; my = br_r; end
      default: begin mx = bi_r; my = bi_r; end
    endcase
  end
  assign mp = mx * my;

  // ops resolved directly from the queue head
  assign s_re = {q_ar[W-1], q_ar} + (q_cls == CL_SUB ? -{q_br[W-1], q_br} : {q_br[W-1], q_br});
  assign s_im = {q_ai[W-1], q_ai} + (q_cls == CL_SUB ? -{q_bi[W-1], q_bi} : {q_bi[W-1], q_bi});
  assign t_re = -{q_ar[W-1], q_ar};
  assign t_im = -{q_ai[W-1], q_ai};
  assign s_re_sat = sat_n1(s_re);
  assign s_im_sat = sat_n1(s_im);
  assign t_re_sat = sat_n1(t_re);
  assign t_im_sat = sat_n1(t_im);

  // multiply combine: round half up, then clamp
  assign m_re_sum = sx(slot_r[0]) - sx(slot_r[1]) + HALF;
  assign m_im_sum = sx(slot_r[2]) + sx(slot_r[3]) + HALF;
  assign m_re_sh  = PW'($signed(m_re_sum) >>> F);
  assign m_im_sh  = PW'($signed(m_im_sum) >>> F);
  assign m_re_sat = sat_p(m_re_sh);
  assign m_im_sat = sat_p(m_im_sh);

  // divide set-up: conj(b) numerators
  assign n_re     = sx(slot_r[0]) + sx(slot_r[1]);
  assign n_im     = sx(slot_r[2]) - sx(slot_r[3]);
  assign n_re_mag = n_re[PW-1] ? -n_re : n_re;
  assign n_im_mag = n_im[PW-1] ? -n_im : n_im;

  // restoring divide step, both parts against one divisor
  assign dsh_re = {rre_r, dre_r[NW-1]};
  assign dsh_im = {rim_r, dim_r[NW-1]};
  assign dge_re = dsh_re >= {1'b0, den_r};
  assign dge_im = dsh_im >= {1'b0, den_r};
  assign ddf_re = dsh_re - {1'b0, den_r};
  assign ddf_im = dsh_im - {1'b0, den_r};
  assign d_re_fin = div_fin(dre_r, nre_r);
  assign d_im_fin = div_fin(dim_r, nim_r);

  // square root step, two radicand bits at a time
  assign ssh    = {srem_r[RW-3:0], rad_r[DW2-1:DW2-2]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sge    = ssh >= strial;
  assign sdf    = ssh - strial;

  always_comb begin
    state_nxt = state_r;
    cls_nxt   = cls_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ch.ready;
    pop_ready = 1'b0;
    mult_en   = 1'b0;
    ar_nxt = ar_r; ai_nxt = ai_r; br_nxt = br_r; bi_nxt = bi_r;
    dre_nxt = dre_r; dim_nxt = dim_r; rre_nxt = rre_r; rim_nxt = rim_r;
    den_nxt = den_r; nre_nxt = nre_r; nim_nxt = nim_r;
    rad_nxt = rad_r; srem_nxt = srem_r; root_nxt = root_r;
    fre_nxt = fre_r; fim_nxt = fim_r; fst_nxt = fst_r;
    ore_nxt = ore_r; oim_nxt = oim_r; oeq_nxt = oeq_r; ost_nxt = ost_r;

    case (state_r)
      BK_IDLE: begin
        if (pop_valid && q_simple && out_free) begin
          pop_ready = 1'b1;
          ov_nxt    = 1'b1;
          oeq_nxt   = 1'b0;
          ore_nxt   = '0;
          oim_nxt   = '0;
          ost_nxt   = ST_OK;
          case (q_cls)
            CL_ADD, CL_SUB: begin
              ore_nxt = s_re_sat[W-1:0];
              oim_nxt = s_im_sat[W-1:0];
              ost_nxt = (s_re_sat[W] || s_im_sat[W]) ? ST_SAT : ST_OK;
            end
            CL_NEG: begin
              ore_nxt = t_re_sat[W-1:0];
              oim_nxt = t_im_sat[W-1:0];
              ost_nxt = (t_re_sat[W] || t_im_sat[W]) ? ST_SAT : ST_OK;
            end
            CL_EQ:   oeq_nxt = q_eq;
            CL_DIVZ: begin
              ore_nxt = q_ar;
              oim_nxt = q_ai;
              ost_nxt = ST_DIVZ;
            end
            default: ;
          endcase
        end else if (pop_valid && !q_simple) begin
          pop_ready = 1'b1;
          cls_nxt   = q_cls;
          ar_nxt = q_ar; ai_nxt = q_ai; br_nxt = q_br; bi_nxt = q_bi;
          k_nxt     = '0;
          state_nxt = BK_MULT;
        end
      end
      BK_MULT: begin
        mult_en = 1'b1;
        k_nxt   = k_r + 1'b1;
        if (k_r == k_last) state_nxt = BK_COMB;
      end
      BK_COMB: begin
        case (cls_r)
          CL_MUL: begin
            fre_nxt   = m_re_sat[W-1:0];
            fim_nxt   = m_im_sat[W-1:0];
            fst_nxt   = (m_re_sat[W] || m_im_sat[W]) ? ST_SAT : ST_OK;
            state_nxt = BK_FIN;
          end
          CL_DIV: begin
            dre_nxt   = NW'(n_re_mag) << F;
            dim_nxt   = NW'(n_im_mag) << F;
            nre_nxt   = n_re[PW-1];
            nim_nxt   = n_im[PW-1];
            rre_nxt   = '0;
            rim_nxt   = '0;
            den_nxt   = slot_r[4] + slot_r[5];
            cnt_nxt   = CW'(NW);
            state_nxt = BK_DIV;
          end
          default: begin
            rad_nxt   = slot_r[0] + slot_r[1];
            srem_nxt  = '0;
            root_nxt  = '0;
            cnt_nxt   = CW'(W);
            state_nxt = BK_SQRT;
          end
        endcase
      end
      BK_DIV: begin
        rre_nxt = dge_re ? ddf_re[DW2-1:0] : dsh_re[DW2-1:0];
        rim_nxt = dge_im ? ddf_im[DW2-1:0] : dsh_im[DW2-1:0];
        dre_nxt = {dre_r[NW-2:0], dge_re};
        dim_nxt = {dim_r[NW-2:0], dge_im};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = BK_FIN;
      end
      BK_SQRT: begin
        srem_nxt = sge ? sdf : ssh;
        root_nxt = {root_r[W-2:0], sge};
        rad_nxt  = rad_r << 2;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oeq_nxt   = 1'b0;
          state_nxt = BK_IDLE;
          case (cls_r)
            CL_MUL: begin
              ore_nxt = fre_r;
              oim_nxt = fim_r;
              ost_nxt = fst_r;
            end
            CL_DIV: begin
              ore_nxt = d_re_fin[W-1:0];
              oim_nxt = d_im_fin[W-1:0];
              ost_nxt = (d_re_fin[W] || d_im_fin[W]) ? ST_SAT : ST_OK;
            end
            default: begin
              ore_nxt = root_r[W-1] ? MAXW : root_r;
              oim_nxt = '0;
              ost_nxt = root_r[W-1] ? ST_SAT : ST_OK;
            end
          endcase
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cls_r   <= CL_NOP;
      k_r     <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cls_r   <= cls_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ar_r <= ar_nxt; ai_r <= ai_nxt; br_r <= br_nxt; bi_r <= bi_nxt;
    dre_r <= dre_nxt; dim_r <= dim_nxt; rre_r <= rre_nxt; rim_r <= rim_nxt;
    den_r <= den_nxt; nre_r <= nre_nxt; nim_r <= nim_nxt;
    rad_r <= rad_nxt; srem_r <= srem_nxt; root_r <= root_nxt;
    fre_r <= fre_nxt; fim_r <= fim_nxt; fst_r <= fst_nxt;
    ore_r <= ore_nxt; oim_r <= oim_nxt; oeq_r <= oeq_nxt; ost_r <= ost_nxt;
    if (mult_en) begin
      slot_r[k_r] <= mp;
    end
  end

endmodule

`default_nettype wire

FILE: src/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_core_defines.svh"

module cau_checker #(
  parameter int W = cau_pkg::WORD_BITS_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [W-1:0]                   out_res_re,
  input wire logic [W-1:0]                   out_res_im,
  input wire logic                           out_is_equal,
  input wire logic [cau_pkg::STATUS_W-1:0]   out_status
);
  import cau_pkg::*;

  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  `CAU_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")
  `CAU_ASSERT_STALL(a_out_stable, {out_res_re, out_res_im, out_is_equal, out_status}, "stalled result changed")
  `CAU_ASSERT(a_eq_clean, (out_valid && out_is_equal) |-> (out_res_re == '0 && out_res_im == '0 && out_status == ST_OK), "equal result not clean")
  `CAU_ASSERT(a_sat_bound, (out_valid && out_status == ST_SAT) |-> (out_res_re == MAXW || out_res_re == MINW || out_res_im == MAXW || out_res_im == MINW), "saturation flagged on in-range result")

endmodule

bind complex_arithmetic_unit_core cau_checker #(.W(WORD_BITS)) u_cau_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_res_re   (out_ch.res_re),
  .out_res_im   (out_ch.res_im),
  .out_is_equal (out_ch.is_equal),
  .out_status   (out_ch.status)
);

`default_nettype wire

FILE: test/tb_complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit_core
// Self-checking bench for the fixed-point complex ALU. Each operation is
// predicted at full width, then compared with the result transactions in
// order, under random idling on both channels in all but the last phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_complex_arithmetic_unit_core;
  import cau_pkg::*;

  localparam int WB        = 32;
  localparam int FB        = 16;
  localparam int STALL_MAX = 20000;
  localparam int TAIL      = 200;

  typedef struct packed {
    logic signed [WB-1:0] re;
    logic signed [WB-1:0] im;
    logic                 eq;
    logic [STATUS_W-1:0]  st;
  } cau_result_t;

  logic clk;
  logic rst_n;

  cau_in_if  #(.W(WB)) in_ch ();
  cau_out_if #(.W(WB)) out_ch ();

  complex_arithmetic_unit_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cau_result_t pending_results[$];
  int          mismatches;
  int          quiet_cycles;
  int          snd_idle;
  int          rcv_idle;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Clamp a wide value to the signed word range
  function automatic logic signed [WB-1:0] clamp_word(input logic signed [127:0] v,
                                                      inout bit sat);
    if (v > 128'sh7fff_ffff) begin
      sat = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -128'sh8000_0000) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[WB-1:0];
  endfunction

  // Expected result of one transaction
  function automatic cau_result_t compute_result(input logic [OPCODE_W-1:0] op,
                                                 input logic signed [WB-1:0] ar,
                                                 input logic signed [WB-1:0] ai,
                                                 input logic signed [WB-1:0] br,
                                                 input logic signed [WB-1:0] bi);
    cau_result_t r;
    bit sat;
    logic signed [127:0] xr, xi, yr, yi, num_re, num_im, den;
    logic [63:0] acc, root, bitv;
    r   = '0;
    sat = 1'b0;
    xr  = ar;
    xi  = ai;
    yr  = br;
    yi  = bi;
    case (opcode_t'(op))
      OP_ADD: begin
        r.re = clamp_word(xr + yr, sat);
        r.im = clamp_word(xi + yi, sat);
      end
      OP_SUB: begin
        r.re = clamp_word(xr - yr, sat);
        r.im = clamp_word(xi - yi, sat);
      end
      OP_MUL: begin
        // round to nearest, ties upward
        num_re = (xr * yr - xi * yi + (128'sd1 <<< (FB - 1))) >>> FB;
        num_im = (xi * yr + xr * yi + (128'sd1 <<< (FB - 1))) >>> FB;
        r.re = clamp_word(num_re, sat);
        r.im = clamp_word(num_im, sat);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.re = ar;
          r.im = ai;
          r.st = ST_DIVZ;
        end else begin
          den    = yr * yr + yi * yi;
          num_re = ((xr * yr + xi * yi) <<< FB) / den;
          num_im = ((xi * yr - xr * yi) <<< FB) / den;
          r.re = clamp_word(num_re, sat);
          r.im = clamp_word(num_im, sat);
        end
      end
      OP_NEG: begin
        r.re = clamp_word(-xr, sat);
        r.im = clamp_word(-xi, sat);
      end
      OP_EQ: r.eq = (ar == br) && (ai == bi);
      OP_MAG: begin
        acc  = 64'(xr * xr + xi * xi);
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > acc) bitv = bitv >> 2;
        while (bitv != 0) begin
          if (acc >= root + bitv) begin
            acc  = acc - (root + bitv);
            root = (root >> 1) + bitv;
          end else begin
            root = root >> 1;
          end
          bitv = bitv >> 2;
        end
        if (root > 64'h7fff_ffff) begin
          root = 64'h7fff_ffff;
          sat  = 1'b1;
        end
        r.re = root[WB-1:0];
      end
      default: r = '0;
    endcase
    if (sat) r.st = ST_SAT;
    return r;
  endfunction

  // Predict on input acceptance, check on result acceptance, watch for a hang
  always @(posedge clk) begin
    cau_result_t exp_r;
    cau_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.res_re, out_ch.res_im, out_ch.is_equal, out_ch.status};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %h", got);
        end else begin
          exp_r = pending_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: re exp %h got %h, im exp %h got %h, eq exp %b got %b, st exp %0d got %0d",
                       exp_r.re, got.re, exp_r.im, got.im, exp_r.eq, got.eq, exp_r.st, got.st);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(compute_result(in_ch.opcode, in_ch.a_re, in_ch.a_im,
                                                 in_ch.b_re, in_ch.b_im));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("FAIL complex_arithmetic_unit_core");
        $finish;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  task automatic send_op(input opcode_t op, input logic signed [WB-1:0] ar,
                         input logic signed [WB-1:0] ai, input logic signed [WB-1:0] br,
                         input logic signed [WB-1:0] bi);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.a_re   <= ar;
    in_ch.a_im   <= ai;
    in_ch.b_re   <= br;
    in_ch.b_im   <= bi;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [WB-1:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'(signed'($urandom_range(6) - 3)) <<< FB;
      3: return 32'(signed'($urandom_range(262143))) - 32'sd131072;
      default: return $urandom;
    endcase
  endfunction

  // Extremes, each operation, zero divisor, equality, unused opcode
  task automatic test_directed();
    send_op(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_op(OP_ADD, 32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 32'sh0001_0000);
    send_op(OP_SUB, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0001, -32'sh0000_0001);
    send_op(OP_SUB, 32'sh0003_0000, 32'sh0, 32'sh0001_0000, 32'sh0);
    send_op(OP_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
    send_op(OP_MUL, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
    send_op(OP_MUL, 32'sh0000_0001, 32'sh0, 32'sh0000_8000, 32'sh0);  // tie
    send_op(OP_MUL, -32'sh0000_0001, 32'sh0, 32'sh0000_8000, 32'sh0);
    send_op(OP_DIV, 32'sh1234_5678, -32'sh0765_4321, 32'sh0, 32'sh0);
    send_op(OP_DIV, 32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000);
    send_op(OP_DIV, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0001, 32'sh0);
    send_op(OP_DIV, -32'sh0001_0000, 32'sh0, 32'sh0003_0000, 32'sh0);
    send_op(OP_DIV, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_op(OP_NEG, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, 32'sh0);
    send_op(OP_NEG, 32'sh0001_0000, -32'sh0000_0005, $urandom, $urandom);
    send_op(OP_EQ, 32'sh0123_4567, -32'sh0000_0010, 32'sh0123_4567, -32'sh0000_0010);
    send_op(OP_EQ, 32'sh0123_4567, -32'sh0000_0010, 32'sh0123_4567, -32'sh0000_0011);
    send_op(OP_EQ, 32'sh0123_4567, 32'sh0, 32'sh0123_4566, 32'sh0);
    send_op(OP_MAG, 32'sh8000_0000, 32'sh8000_0000, 32'sh0, 32'sh0);
    send_op(OP_MAG, 32'sh0000_0003, 32'sh0000_0004, 32'sh0, 32'sh0);
    send_op(OP_MAG, 32'sh7fff_ffff, 32'sh0, 32'sh0, 32'sh0);
    send_op(OP_NONE, 32'sh7fff_ffff, 32'sh8000_0000, $urandom, $urandom);
    drop_valid();
  endtask

  task automatic test_random(input int n_items);
    logic signed [WB-1:0] ar, ai, br, bi;
    opcode_t op;
    for (int i = 0; i < n_items; i++) begin
      op = opcode_t'($urandom_range(7));
      ar = rand_word();
      ai = rand_word();
      br = rand_word();
      bi = rand_word();
      if (op == OP_EQ && $urandom_range(1)) begin
        br = ar;
        bi = $urandom_range(1) ? ai : ai ^ (32'sd1 <<< $urandom_range(31));
      end
      if (op == OP_DIV && $urandom_range(7) == 0) begin
        br = '0;
        bi = '0;
      end
      send_op(op, ar, ai, br, bi);
    end
    drop_valid();
  endtask

  // Sender holds off until every outstanding result has drained
  task automatic test_drain_then_burst();
    wait (pending_results.size() == 0);
    test_random(40);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.a_re   = '0;
    in_ch.a_im   = '0;
    in_ch.b_re   = '0;
    in_ch.b_im   = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    snd_idle     = 29;
    rcv_idle     = 49;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(650);
    snd_idle = 49;
    rcv_idle = 29;
    test_random(650);
    test_drain_then_burst();
    snd_idle = 0;
    rcv_idle = 0;
    test_random(650);

    wait (pending_results.size() == 0);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS complex_arithmetic_unit_core");
    else
      $display("FAIL complex_arithmetic_unit_core");
    $finish;
  end

endmodule

`default_nettype wire

FILE: complex_arithmetic_unit_core.f
+incdir+src
src/cau_pkg.sv
src/cau_if.sv
src/cau_front.sv
src/cau_queue.sv
src/cau_back.sv
src/complex_arithmetic_unit_core.sv
src/cau_checker.sv
test/tb_complex_arithmetic_unit_core.sv
